FILE: hw/rtl/xtea_pkg.sv
`timescale 1ns / 1ps

package xtea_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int STAGE_COUNT = 2 * ROUND_COUNT;
    localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

    localparam int KEY_COUNT = 4;
    localparam int KEY_IDX_W = 2;
    localparam int PADDR_W = 4;

    localparam logic [KEY_IDX_W-1:0] KEY_ZERO_IDX = 2'd0;
    localparam logic [KEY_IDX_W-1:0] KEY_ONE_IDX = 2'd1;
    localparam logic [KEY_IDX_W-1:0] KEY_TWO_IDX = 2'd2;
    localparam logic [KEY_IDX_W-1:0] KEY_THREE_IDX = 2'd3;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } pipe_t;

    function automatic logic [31:0] round_sum(input int n);
        logic [63:0] product;
        product = 64'(n) * 64'(XTEA_DELTA);
        return product[31:0];
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

FILE: hw/rtl/xtea_stage.sv
`timescale 1ns / 1ps

module xtea_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                even_half,
    input  logic [31:0]         enc_sum,
    input  logic [31:0]         dec_sum,
    input  logic [31:0]         enc_key,
    input  logic [31:0]         dec_key,
    input  logic                valid_in,
    input  xtea_pkg::pipe_t     data_in,
    output logic                valid_out,
    output xtea_pkg::pipe_t     data_out
);
    import xtea_pkg::*;

    logic        valid_reg;
    pipe_t       data_reg;
    pipe_t       data_next;
    logic        update_y;
    logic [31:0] sum_sel;
    logic [31:0] key_sel;
    logic [31:0] src_word;
    logic [31:0] dst_word;
    logic [31:0] delta_word;
    logic [31:0] new_word;

    // encrypt updates y on even half rounds, decrypt updates z on even half rounds
    assign update_y = even_half ^ (data_in.mode == MODE_DECRYPT);

    always_comb
    begin
        sum_sel = (data_in.mode == MODE_DECRYPT) ? dec_sum : enc_sum;
        key_sel = (data_in.mode == MODE_DECRYPT) ? dec_key : enc_key;
        src_word = update_y ? data_in.z : data_in.y;
        dst_word = update_y ? data_in.y : data_in.z;
        delta_word = mix(src_word) ^ (sum_sel + key_sel);
        new_word = (data_in.mode == MODE_DECRYPT) ? (dst_word - delta_word)
                                                  : (dst_word + delta_word);
        data_next = data_in;
        if (update_y)
        begin
            data_next.y = new_word;
        end
        else
        begin
            data_next.z = new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out = data_reg;

endmodule

FILE: hw/rtl/xtea_block_cipher_unit.sv
`timescale 1ns / 1ps
// each accepted item passes through every stage before its result is valid, one half round per stage
// throughput: one item per cycle while out_stall does not hold it, set by the 64-stage half-round pipeline
// the whole pipeline holds while the output stage has a result and out_stall is high
// reset: asynchronous active-low rst_n clears all stage valid bits and the four key words
// key words are read live by every stage; the user must rewrite them only with the pipeline empty (not enforced)

module xtea_block_cipher_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [xtea_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [31:0]                   low_word,
    input  logic [31:0]                   high_word,
    input  logic                          last_block,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [31:0]                   out_low_word,
    output logic [31:0]                   out_high_word,
    output logic                          out_last_block
);
    import xtea_pkg::*;

    logic [31:0]          key_word_reg [KEY_COUNT];
    logic [KEY_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    logic                 advance;
    logic                 stage_valid [STAGE_COUNT+1];
    pipe_t                stage_data [STAGE_COUNT+1];

    assign pready = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-KEY_IDX_W];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                key_word_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                KEY_ZERO_IDX:  key_word_reg[KEY_ZERO_IDX]  <= pwdata;
                KEY_ONE_IDX:   key_word_reg[KEY_ONE_IDX]   <= pwdata;
                KEY_TWO_IDX:   key_word_reg[KEY_TWO_IDX]   <= pwdata;
                KEY_THREE_IDX: key_word_reg[KEY_THREE_IDX] <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            KEY_ZERO_IDX:  prdata = key_word_reg[KEY_ZERO_IDX];
            KEY_ONE_IDX:   prdata = key_word_reg[KEY_ONE_IDX];
            KEY_TWO_IDX:   prdata = key_word_reg[KEY_TWO_IDX];
            KEY_THREE_IDX: prdata = key_word_reg[KEY_THREE_IDX];
            default:       prdata = '0;
        endcase
    end

    assign advance = !(stage_valid[STAGE_COUNT] && out_stall);
    assign in_stall = !advance;

    always_comb
    begin
        stage_valid[0] = in_valid;
        stage_data[0].mode = mode;
        stage_data[0].y = low_word;
        stage_data[0].z = high_word;
        stage_data[0].last = last_block;
    end

    for (genvar h = 0; h < STAGE_COUNT; h++)
    begin : g_stage
        localparam int RND = h / 2;
        localparam bit EVEN = (h % 2) == 0;
        localparam logic [31:0] ENC_SUM = EVEN ? round_sum(RND) : round_sum(RND + 1);
        localparam logic [31:0] DEC_SUM = EVEN ? round_sum(ROUND_COUNT - RND)
                                               : round_sum(ROUND_COUNT - 1 - RND);
        localparam logic [KEY_IDX_W-1:0] ENC_IDX = EVEN ? ENC_SUM[1:0] : ENC_SUM[12:11];
        localparam logic [KEY_IDX_W-1:0] DEC_IDX = EVEN ? DEC_SUM[12:11] : DEC_SUM[1:0];

        xtea_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .even_half (EVEN),
            .enc_sum   (ENC_SUM),
            .dec_sum   (DEC_SUM),
            .enc_key   (key_word_reg[ENC_IDX]),
            .dec_key   (key_word_reg[DEC_IDX]),
            .valid_in  (stage_valid[h]),
            .data_in   (stage_data[h]),
            .valid_out (stage_valid[h+1]),
            .data_out  (stage_data[h+1])
        );
    end

    assign out_valid = stage_valid[STAGE_COUNT];
    assign out_low_word = stage_data[STAGE_COUNT].y;
    assign out_high_word = stage_data[STAGE_COUNT].z;
    assign out_last_block = stage_data[STAGE_COUNT].last;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

class cipher_scoreboard;
    typedef struct {
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } block_t;

    logic [31:0] key_word [4];
    block_t      expected_blocks [$];
    int          errors;

    function new();
        foreach (key_word[i])
        begin
            key_word[i] = '0;
        end
        errors = 0;
    endfunction

    function void set_key(logic [1:0] idx, logic [31:0] value);
        key_word[idx] = value;
    endfunction

    function logic [31:0] round_mix(logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    function block_t cipher_block(logic m, logic [31:0] y, logic [31:0] z, logic last);
        block_t      res;
        logic [31:0] sum;
        if (m == xtea_pkg::MODE_DECRYPT)
        begin
            sum = xtea_pkg::XTEA_DELTA * xtea_pkg::ROUND_COUNT;
            for (int r = 0; r < xtea_pkg::ROUND_COUNT; r++)
            begin
                z -= round_mix(y) ^ (sum + key_word[sum[12:11]]);
                sum -= xtea_pkg::XTEA_DELTA;
                y -= round_mix(z) ^ (sum + key_word[sum[1:0]]);
            end
        end
        else
        begin
            sum = '0;
            for (int r = 0; r < xtea_pkg::ROUND_COUNT; r++)
            begin
                y += round_mix(z) ^ (sum + key_word[sum[1:0]]);
                sum += xtea_pkg::XTEA_DELTA;
                z += round_mix(y) ^ (sum + key_word[sum[12:11]]);
            end
        end
        res.y = y;
        res.z = z;
        res.last = last;
        return res;
    endfunction

    function void note_input(logic m, logic [31:0] y, logic [31:0] z, logic last);
        expected_blocks.push_back(cipher_block(m, y, z, last));
    endfunction

    function void check_result(logic [31:0] y, logic [31:0] z, logic last);
        block_t want;
        if (expected_blocks.size() == 0)
        begin
            $display("%0t: unexpected result: y=%h z=%h last=%b", $time, y, z, last);
            errors++;
            return;
        end
        want = expected_blocks.pop_front();
        if (want.y !== y)
        begin
            $display("%0t: out_low_word expected %h actual %h", $time, want.y, y);
            errors++;
        end
        if (want.z !== z)
        begin
            $display("%0t: out_high_word expected %h actual %h", $time, want.z, z);
            errors++;
        end
        if (want.last !== last)
        begin
            $display("%0t: out_last_block expected %b actual %b", $time, want.last, last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import xtea_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_CYCLES = STAGE_COUNT + 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 165;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [31:0]        low_word;
    logic [31:0]        high_word;
    logic               last_block;
    logic               out_valid;
    logic               out_stall;
    logic [31:0]        out_low_word;
    logic [31:0]        out_high_word;
    logic               out_last_block;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_start = 1'b0;
    int hold_count = 0;
    int cycle_count = 0;

    cipher_scoreboard sb = new();

    xtea_block_cipher_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .low_word       (low_word),
        .high_word      (high_word),
        .last_block     (last_block),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_low_word   (out_low_word),
        .out_high_word  (out_high_word),
        .out_last_block (out_last_block)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: check, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_result(out_low_word, out_high_word, out_last_block);
            end
            if (hold_start && hold_count < HOLD_CYCLES)
            begin
                hold_count++;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_key(logic [KEY_IDX_W-1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_key(idx, value);
    endtask

    task automatic write_keys(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                              logic [31:0] k3);
        write_key(KEY_ZERO_IDX, k0);
        write_key(KEY_ONE_IDX, k1);
        write_key(KEY_TWO_IDX, k2);
        write_key(KEY_THREE_IDX, k3);
    endtask

    task automatic send_block(logic m, logic [31:0] y, logic [31:0] z, logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        low_word <= y;
        high_word <= z;
        last_block <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_input(m, y, z, last);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.expected_blocks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
        begin
            send_block(1'($urandom_range(1)), rand_word(), rand_word(),
                       $urandom_range(7) == 0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        mode = MODE_ENCRYPT;
        low_word = '0;
        high_word = '0;
        last_block = 1'b0;
        out_stall = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keys still at their reset value
        send_block(MODE_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_block(MODE_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1);
        wait_idle();

        write_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(MODE_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_block(MODE_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_block(MODE_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0);
        send_block(MODE_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b1);
        wait_idle();

        write_keys(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
        send_block(MODE_ENCRYPT, 32'h4142_4344, 32'h4546_4748, 1'b0);
        send_block(MODE_DECRYPT, 32'h4142_4344, 32'h4546_4748, 1'b0);
        send_block(MODE_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_block(MODE_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        send_block(MODE_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_block(MODE_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_random(6);
        wait_idle();

        write_keys($urandom, $urandom, $urandom, $urandom);
        tx_idle_pct = 14;
        rx_idle_pct = 87;
        send_random(PHASE_ITEMS);
        wait_idle();

        write_keys(32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom);
        tx_idle_pct = 87;
        rx_idle_pct = 14;
        send_random(PHASE_ITEMS);
        wait_idle();

        // long receiver hold-off while items keep coming, fills the pipeline
        write_keys($urandom, $urandom, $urandom, $urandom);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_start = 1'b1;
        send_random(PHASE_ITEMS);
        wait_idle();

        if (sb.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
